[rtl/iec_pkg.sv]
package iec_pkg;

   localparam logic [7:0] CH_X      = 8'h78;
   localparam logic [7:0] CH_E      = 8'h65;
   localparam logic [7:0] CH_P      = 8'h70;
   localparam logic [7:0] CH_S      = 8'h73;
   localparam logic [7:0] CH_C      = 8'h63;
   localparam logic [7:0] CH_T      = 8'h74;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_DOT    = 8'h2e;
   localparam logic [7:0] CH_CARET  = 8'h5e;
   localparam logic [7:0] CH_STAR   = 8'h2a;
   localparam logic [7:0] CH_PLUS   = 8'h2b;
   localparam logic [7:0] CH_MINUS  = 8'h2d;
   localparam logic [7:0] CH_SLASH  = 8'h2f;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;

   localparam int unsigned FEED_SLOTS = 3;

   // rewritten characters of one request, applied in slot order
   typedef struct packed {
      logic [FEED_SLOTS-1:0]      vld;
      logic [FEED_SLOTS-1:0][7:0] chr;
   } feed_type;

   function automatic logic is_dig(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic is_op(input logic [7:0] c);
      return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) ||
             (c == CH_SLASH) || (c == CH_CARET);
   endfunction

   function automatic logic is_fn(input logic [7:0] c);
      return (c == CH_S) || (c == CH_C) || (c == CH_T);
   endfunction

   function automatic logic is_mul(input logic [7:0] c);
      return (c == CH_X) || (c == CH_E) || (c == CH_P) || is_fn(c) || (c == CH_LPAREN);
   endfunction

   function automatic logic is_opd(input logic [7:0] c);
      return is_mul(c) || (c == CH_DOT);
   endfunction

   function automatic logic ends_ok(input logic [7:0] c);
      return is_dig(c) || (c == CH_X) || (c == CH_E) || (c == CH_P) || (c == CH_DOT);
   endfunction

   function automatic logic after_value(input logic [7:0] c);
      return is_dig(c) || is_op(c) || (c == CH_RPAREN);
   endfunction

endpackage

[rtl/iec_format.sv]
module iec_format (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  logic [7:0]        char_code,
   input  logic              is_last,
   output iec_pkg::feed_type feed
);

   logic [7:0] pending_raw_ff, pending_raw_in;
   logic       have_pending_ff, have_pending_in;
   logic [7:0] before_raw_ff, before_raw_in;
   logic       first_ff, first_in;
   logic [1:0] skip_left_ff, skip_left_in;

   logic [7:0] t;
   logic       a_vld, b_vld;
   logic [7:0] a_chr, b_chr;
   logic [1:0] skip_new;
   logic       hold;

   always_comb begin
      t        = pending_raw_ff;
      a_vld    = 1'b0;
      b_vld    = 1'b0;
      a_chr    = t;
      b_chr    = iec_pkg::CH_STAR;
      skip_new = skip_left_ff;
      if (have_pending_ff) begin
         skip_new = 2'd0;
         a_vld    = 1'b1;
         if ((iec_pkg::is_dig(t) || (t != iec_pkg::CH_LPAREN && iec_pkg::is_mul(t)) ||
              t == iec_pkg::CH_RPAREN) && iec_pkg::is_mul(char_code)) begin
            b_vld = !iec_pkg::is_fn(t);
         end else if (t == iec_pkg::CH_MINUS) begin
            if (first_ff || before_raw_ff == iec_pkg::CH_LPAREN) begin
               a_chr = iec_pkg::CH_ZERO;
               b_vld = 1'b1;
               b_chr = iec_pkg::CH_MINUS;
            end
         end else if (iec_pkg::is_fn(t)) begin
            skip_new = 2'd2;
         end else if (t == iec_pkg::CH_P) begin
            skip_new = 2'd1;
         end
      end

      hold            = (skip_new == 2'd0);
      skip_left_in    = hold ? 2'd0 : 2'(skip_new - 2'd1);
      have_pending_in = hold;
      before_raw_in   = hold ? pending_raw_ff : before_raw_ff;
      pending_raw_in  = char_code;
      first_in        = have_pending_ff ? 1'b0 : first_ff;

      // last raw character has no look-ahead and passes through unchanged
      feed.vld    = {is_last && have_pending_in, b_vld, a_vld};
      feed.chr[0] = a_chr;
      feed.chr[1] = b_chr;
      feed.chr[2] = char_code;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_raw_ff  <= '0;
         have_pending_ff <= 1'b0;
         before_raw_ff   <= '0;
         first_ff        <= 1'b1;
         skip_left_ff    <= '0;
      end else if (fire) begin
         if (is_last) begin
            pending_raw_ff  <= '0;
            have_pending_ff <= 1'b0;
            before_raw_ff   <= '0;
            first_ff        <= 1'b1;
            skip_left_ff    <= '0;
         end else begin
            pending_raw_ff  <= pending_raw_in;
            have_pending_ff <= have_pending_in;
            before_raw_ff   <= before_raw_in;
            first_ff        <= first_in;
            skip_left_ff    <= skip_left_in;
         end
      end
   end

endmodule

[rtl/iec_validate.sv]
module iec_validate #(
   parameter int unsigned MAX_PAREN_DEPTH = 255
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  logic              is_last,
   input  iec_pkg::feed_type feed,
   output logic              is_valid
);

   localparam int unsigned DW = $clog2(MAX_PAREN_DEPTH + 1);
   localparam logic [DW-1:0] MAX_D = DW'(MAX_PAREN_DEPTH);

   typedef struct packed {
      logic [7:0]    held;
      logic [1:0]    cnt;
      logic          dot;
      logic [DW-1:0] depth;
      logic          failed;
   } vstate_type;

   function automatic vstate_type feed_char(input vstate_type s, input logic [7:0] f);
      vstate_type r;
      logic [7:0] t;
      r = s;
      t = s.held;
      if (s.cnt == 2'd0) begin
         r.held = f;
         r.cnt  = 2'd1;
      end else begin
         if (s.cnt == 2'd1) begin
            if (iec_pkg::is_op(t)) r.failed = 1'b1;
            r.cnt = 2'd2;
         end
         if (!r.failed) begin
            if (iec_pkg::is_dig(t)) begin
               if (f == iec_pkg::CH_DOT) begin
                  if (r.dot) r.failed = 1'b1;
                  else r.dot = 1'b1;
               end else if (!iec_pkg::after_value(f)) begin
                  r.failed = 1'b1;
               end
            end else if (t == iec_pkg::CH_DOT) begin
               if (f == iec_pkg::CH_DOT || !iec_pkg::after_value(f)) r.failed = 1'b1;
            end else if (t == iec_pkg::CH_LPAREN) begin
               if (r.depth >= MAX_D) r.failed = 1'b1;
               else r.depth = DW'(r.depth + 1'b1);
               if (f == iec_pkg::CH_RPAREN ||
                   (!iec_pkg::is_opd(f) && !iec_pkg::is_dig(f))) r.failed = 1'b1;
            end else if (t == iec_pkg::CH_RPAREN) begin
               r.dot = 1'b0;
               if (r.depth == '0) r.failed = 1'b1;
               else r.depth = DW'(r.depth - 1'b1);
               if (!iec_pkg::is_op(f) && f != iec_pkg::CH_RPAREN) r.failed = 1'b1;
            end else if (iec_pkg::is_fn(t)) begin
               if (!iec_pkg::is_opd(f)) r.failed = 1'b1;
            end else if (t == iec_pkg::CH_X || t == iec_pkg::CH_E || t == iec_pkg::CH_P) begin
               if (!iec_pkg::is_op(f) && f != iec_pkg::CH_RPAREN) r.failed = 1'b1;
            end else if (iec_pkg::is_op(t)) begin
               r.dot = 1'b0;
               if (!iec_pkg::is_opd(f) && !iec_pkg::is_dig(f)) r.failed = 1'b1;
            end else begin
               r.failed = 1'b1;
            end
         end
         r.held = f;
      end
      return r;
   endfunction

   vstate_type st_ff, st_in;
   vstate_type st_mid [iec_pkg::FEED_SLOTS+1];

   always_comb begin
      st_mid[0] = st_ff;
      for (int i = 0; i < iec_pkg::FEED_SLOTS; i++) begin
         st_mid[i+1] = feed.vld[i] ? feed_char(st_mid[i], feed.chr[i]) : st_mid[i];
      end
      st_in = st_mid[iec_pkg::FEED_SLOTS];

      if (st_in.cnt == 2'd0) begin
         is_valid = 1'b0;
      end else if (st_in.cnt == 2'd1) begin
         is_valid = iec_pkg::ends_ok(st_in.held);
      end else if (st_in.held == iec_pkg::CH_RPAREN) begin
         is_valid = !st_in.failed && (st_in.depth == DW'(1));
      end else begin
         is_valid = !st_in.failed && (st_in.depth == '0) && iec_pkg::ends_ok(st_in.held);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= '0;
      end else if (fire) begin
         if (is_last) st_ff <= '0;
         else st_ff <= st_in;
      end
   end

endmodule

[rtl/infix_expression_checker.sv]
// channel   | direction | ports
// request   | in        | req_valid, req_stall (out), req_char_code[7:0], req_is_last
// response  | out       | rsp_valid, rsp_stall (in), rsp_is_valid
//
// one character per cycle unless req_stall is high: a request is registered, then
// rewritten and checked combinationally; the last character's check is registered
// a spare register takes a second response while the first one is stalled
// synchronous reset and each expression end clear check state; reset also the flags
// req_stall rises only while a last character waits and both response slots are full
module infix_expression_checker #(
   parameter int unsigned MAX_PAREN_DEPTH = 255
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_char_code,
   input  logic       req_is_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_is_valid
);

   logic       in_valid_ff;
   logic [7:0] in_char_ff;
   logic       in_last_ff;
   logic       rsp_valid_ff;
   logic       rsp_is_valid_ff;
   logic       spare_valid_ff;
   logic       spare_is_valid_ff;

   logic              advance;
   logic              produce;
   logic              pop;
   logic              accept;
   logic              check_ok;
   iec_pkg::feed_type feed;

   assign advance   = in_valid_ff && !(in_last_ff && spare_valid_ff);
   assign produce   = advance && in_last_ff;
   assign pop       = rsp_valid_ff && !rsp_stall;
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_is_valid = rsp_is_valid_ff;

   iec_format u_format (
      .clock     (clock),
      .reset     (reset),
      .fire      (advance),
      .char_code (in_char_ff),
      .is_last   (in_last_ff),
      .feed      (feed)
   );

   iec_validate #(
      .MAX_PAREN_DEPTH (MAX_PAREN_DEPTH)
   ) u_validate (
      .clock    (clock),
      .reset    (reset),
      .fire     (advance),
      .is_last  (in_last_ff),
      .feed     (feed),
      .is_valid (check_ok)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         spare_valid_ff <= 1'b0;
      end else begin
         if (accept) in_valid_ff <= 1'b1;
         else if (advance) in_valid_ff <= 1'b0;
         if (spare_valid_ff) begin
            if (pop) spare_valid_ff <= 1'b0;
         end else if (produce) begin
            if (rsp_valid_ff && !pop) spare_valid_ff <= 1'b1;
            else rsp_valid_ff <= 1'b1;
         end else if (pop) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         in_char_ff <= req_char_code;
         in_last_ff <= req_is_last;
      end
      if (spare_valid_ff) begin
         if (pop) rsp_is_valid_ff <= spare_is_valid_ff;
      end else if (produce) begin
         if (rsp_valid_ff && !pop) spare_is_valid_ff <= check_ok;
         else rsp_is_valid_ff <= check_ok;
      end
   end

   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(produce))
      else $error("response without a last request");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_last_ff && spare_valid_ff && rsp_valid_ff))
      else $error("request stalled without a blocked response");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> (rsp_valid_ff && $stable(rsp_is_valid_ff)))
      else $error("pending response lost or changed");

endmodule
